>>> sv/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg: shared types, constants and microcode for the DC motor step block
// Holds the fixed-point formats, the control word layout and the microcode
// table that sequences one Euler step on a single shared multiplier.
// ----------------------------------------------------------------------------
package dcm_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int CMD_SHIFT  = 12;
   localparam int DT_BITS    = 32;

   localparam int COEF_W     = 48;
   localparam int GAIN_W     = 47;
   localparam int STATE_W    = 48;
   localparam int WIDE_W     = 64;
   localparam int HALF_W     = 32;
   localparam int PROD_W     = 128;
   localparam int DT_W       = 32;
   localparam int CMD_W      = 16;
   localparam int POS_W      = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int STEP_W     = 5;
   localparam int PH_W       = 3;

   localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;

   localparam logic [GAIN_W-1:0] FSV_RESET = 47'd201326592;
   localparam logic [GAIN_W-1:0] TPR_RESET = 47'd534035371;

   localparam logic signed [WIDE_W-1:0]  WIDE_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0]  WIDE_MIN  = 64'sh8000_0000_0000_0000;
   localparam logic signed [STATE_W-1:0] STATE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [STATE_W-1:0] STATE_MIN = 48'sh8000_0000_0000;

   // Phases of a multiply step.
   localparam logic [PH_W-1:0] PH_LOAD      = 3'd0;
   localparam logic [PH_W-1:0] PH_ACC_FIRST = 3'd2;
   localparam logic [PH_W-1:0] PH_ACC_LAST  = 3'd5;
   localparam logic [PH_W-1:0] PH_SAT       = 3'd6;
   localparam logic [PH_W-1:0] PH_WRITE     = 3'd7;

   // Entry points of the microprogram.
   localparam logic [STEP_W-1:0] STEP_M2   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_M1   = 5'd13;
   localparam logic [STEP_W-1:0] STEP_M0   = 5'd18;
   localparam logic [STEP_W-1:0] STEP_TAIL = 5'd19;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_SPEED_SELF     = 3'd1,
      CSR_SPEED_FROM_CUR = 3'd2,
      CSR_CUR_FROM_SPEED = 3'd3,
      CSR_CUR_SELF       = 3'd4,
      CSR_DRIVE_GAIN     = 3'd5,
      CSR_FULL_SCALE     = 3'd6,
      CSR_TICKS          = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef enum logic [3:0] {
      A_SS, A_SFC, A_CFS, A_CS, A_DG, A_T, A_W, A_ANG, A_FSV
   } a_sel_type;

   typedef enum logic [2:0] {
      B_DT, B_W, B_I, B_U, B_CMD, B_TPR
   } b_sel_type;

   typedef enum logic [1:0] {
      SH_FRAC, SH_DT, SH_CMD
   } sh_type;

   typedef enum logic [2:0] {
      D_NONE, D_T, D_NW, D_NI, D_W, D_ANG, D_U
   } dst_type;

   typedef enum logic [1:0] {
      J_NEXT, J_ALWAYS, J_MODE0, J_MODE1
   } jmp_type;

   typedef struct packed {
      logic              mul;
      logic              init;
      logic              commit_w;
      logic              commit_i;
      logic              last;
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      sh_type            sh;
      dst_type           dst;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type mul_word(input a_sel_type a, input b_sel_type b,
                                          input sh_type sh, input dst_type dst);
      ucode_type w;
      w       = '0;
      w.mul   = 1'b1;
      w.a_sel = a;
      w.b_sel = b;
      w.sh    = sh;
      w.dst   = dst;
      return w;
   endfunction

   // Microprogram. Old speed, current and voltage are read until the commit
   // steps, so mode 1 and 2 rate terms use the state from the start of the step.
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         5'd0: begin
            w.init   = 1'b1;
            w.jmp    = J_MODE0;
            w.target = STEP_M0;
         end
         5'd1: begin
            w.jmp    = J_MODE1;
            w.target = STEP_M1;
         end
         5'd2:  w = mul_word(A_SS,  B_DT, SH_DT,   D_T);
         5'd3:  w = mul_word(A_T,   B_W,  SH_FRAC, D_NW);
         5'd4:  w = mul_word(A_CFS, B_DT, SH_DT,   D_T);
         5'd5:  w = mul_word(A_T,   B_W,  SH_FRAC, D_NI);
         5'd6:  w = mul_word(A_SFC, B_DT, SH_DT,   D_T);
         5'd7:  w = mul_word(A_T,   B_I,  SH_FRAC, D_NW);
         5'd8:  w = mul_word(A_CS,  B_DT, SH_DT,   D_T);
         5'd9:  w = mul_word(A_T,   B_I,  SH_FRAC, D_NI);
         5'd10: w = mul_word(A_DG,  B_DT, SH_DT,   D_T);
         5'd11: w = mul_word(A_T,   B_U,  SH_FRAC, D_NI);
         5'd12: begin
            w.commit_w = 1'b1;
            w.commit_i = 1'b1;
            w.jmp      = J_ALWAYS;
            w.target   = STEP_TAIL;
         end
         5'd13: w = mul_word(A_SS,  B_DT, SH_DT,   D_T);
         5'd14: w = mul_word(A_T,   B_W,  SH_FRAC, D_NW);
         5'd15: w = mul_word(A_DG,  B_DT, SH_DT,   D_T);
         5'd16: w = mul_word(A_T,   B_U,  SH_FRAC, D_NW);
         5'd17: begin
            w.commit_w = 1'b1;
            w.jmp      = J_ALWAYS;
            w.target   = STEP_TAIL;
         end
         5'd18: begin
            w        = mul_word(A_SFC, B_U, SH_FRAC, D_W);
            w.jmp    = J_ALWAYS;
            w.target = STEP_TAIL;
         end
         5'd19: w = mul_word(A_W,   B_DT,  SH_DT,  D_ANG);
         5'd20: w = mul_word(A_FSV, B_CMD, SH_CMD, D_U);
         5'd21: begin
            // The encoder count is taken from the saturate phase of this step.
            w      = mul_word(A_ANG, B_TPR, SH_FRAC, D_NONE);
            w.last = 1'b1;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

   function automatic logic [WIDE_W-1:0] mag64(input logic signed [WIDE_W-1:0] v);
      return v[WIDE_W-1] ? (64'd0 - v) : v;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sat_add64(input logic signed [WIDE_W-1:0] a,
                                                          input logic signed [WIDE_W-1:0] b);
      logic [WIDE_W:0] s;
      s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      if (s[WIDE_W] != s[WIDE_W-1]) begin
         return s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
      end
      return $signed(s[WIDE_W-1:0]);
   endfunction

   function automatic logic signed [STATE_W-1:0] clamp48(input logic signed [WIDE_W-1:0] v);
      if (v[WIDE_W-1:STATE_W-1] == {(WIDE_W-STATE_W+1){v[WIDE_W-1]}}) begin
         return v[STATE_W-1:0];
      end
      return v[WIDE_W-1] ? STATE_MIN : STATE_MAX;
   endfunction

endpackage

>>> sv/dc_motor_model_step.sv
// ----------------------------------------------------------------------------
// dc_motor_model_step: microcoded forward-Euler DC motor model
// Each request beat advances speed, angle, drive voltage and (mode 2) current by
// one time step and returns the encoder position count on the response channel.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_time_step, req_drive_command
//   rsp      out        rsp_valid/rsp_stall   rsp_position_count
//   csr      in         csr_wr_en             csr_index, csr_wr_data
//
// A multiply step runs on the single 32x32 multiplier through a load phase,
// four partial products, saturate and write-back.
// A new request is taken only after the count has moved into the response
// register.
// Synchronous reset clears the motor state and loads the register defaults.
// A stalled response holds in its register while the next request is taken.
// ----------------------------------------------------------------------------
module dc_motor_model_step
   import dcm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [DT_W-1:0]              req_time_step,
   input  logic signed [CMD_W-1:0]      req_drive_command,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POS_W-1:0]      rsp_position_count,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wr_data
);

   state_type                   state_ff, state_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [PH_W-1:0]             ph_ff, ph_in;

   logic [MODE_W-1:0]           mode_ff, mode_in;
   logic signed [COEF_W-1:0]    ss_ff, ss_in;
   logic signed [COEF_W-1:0]    sfc_ff, sfc_in;
   logic signed [COEF_W-1:0]    cfs_ff, cfs_in;
   logic signed [COEF_W-1:0]    cs_ff, cs_in;
   logic signed [COEF_W-1:0]    dg_ff, dg_in;
   logic [GAIN_W-1:0]           fsv_ff, fsv_in;
   logic [GAIN_W-1:0]           tpr_ff, tpr_in;

   logic signed [STATE_W-1:0]   w_ff, w_in;
   logic signed [STATE_W-1:0]   i_ff, i_in;
   logic signed [STATE_W-1:0]   u_ff, u_in;
   logic signed [WIDE_W-1:0]    ang_ff, ang_in;

   logic [DT_W-1:0]             dt_ff, dt_in;
   logic signed [CMD_W-1:0]     cmd_ff, cmd_in;
   logic signed [WIDE_W-1:0]    t_ff, t_in;
   logic signed [WIDE_W-1:0]    nw_ff, nw_in;
   logic signed [WIDE_W-1:0]    ni_ff, ni_in;
   logic [WIDE_W-1:0]           mag_a_ff, mag_a_in;
   logic [WIDE_W-1:0]           mag_b_ff, mag_b_in;
   logic                        neg_ff, neg_in;
   logic [WIDE_W-1:0]           prod_ff, prod_in;
   logic [1:0]                  prod_sh_ff, prod_sh_in;
   logic [PROD_W-1:0]           acc_ff, acc_in;
   logic signed [WIDE_W-1:0]    res_ff, res_in;
   logic [POS_W-1:0]            pcnt_ff, pcnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]     rsp_count_ff, rsp_count_in;

   ucode_type                   cw;
   logic signed [WIDE_W-1:0]    op_a, op_b;
   logic [1:0]                  part;
   logic [HALF_W-1:0]           a_half, b_half;
   logic [PROD_W-1:0]           mag_sh;
   logic                        ovf;
   logic                        step_done;
   logic                        jump_taken;
   logic                        rsp_load;

   assign cw = ucode(step_ff);

   // Operand select to 64 bits: signed values sign-extended, dt/fsv/tpr zero-extended.
   always_comb begin
      case (cw.a_sel)
         A_SS:    op_a = WIDE_W'(ss_ff);
         A_SFC:   op_a = WIDE_W'(sfc_ff);
         A_CFS:   op_a = WIDE_W'(cfs_ff);
         A_CS:    op_a = WIDE_W'(cs_ff);
         A_DG:    op_a = WIDE_W'(dg_ff);
         A_T:     op_a = t_ff;
         A_W:     op_a = WIDE_W'(w_ff);
         A_ANG:   op_a = ang_ff;
         A_FSV:   op_a = $signed(WIDE_W'(fsv_ff));
         default: op_a = '0;
      endcase
      case (cw.b_sel)
         B_DT:    op_b = $signed(WIDE_W'(dt_ff));
         B_W:     op_b = WIDE_W'(w_ff);
         B_I:     op_b = WIDE_W'(i_ff);
         B_U:     op_b = WIDE_W'(u_ff);
         B_CMD:   op_b = WIDE_W'(cmd_ff);
         B_TPR:   op_b = $signed(WIDE_W'(tpr_ff));
         default: op_b = '0;
      endcase
   end

   // Partial products in the order lo*lo, lo*hi, hi*lo, hi*hi.
   assign part   = 2'(ph_ff - 3'd1);
   assign a_half = part[1] ? mag_a_ff[WIDE_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
   assign b_half = part[0] ? mag_b_ff[WIDE_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];

   always_comb begin
      case (cw.sh)
         SH_FRAC: mag_sh = acc_ff >> FRAC_BITS;
         SH_DT:   mag_sh = acc_ff >> DT_BITS;
         SH_CMD:  mag_sh = acc_ff >> CMD_SHIFT;
         default: mag_sh = acc_ff;
      endcase
   end

   assign ovf = |mag_sh[PROD_W-1:WIDE_W-1];

   assign step_done = !cw.mul || (ph_ff == PH_WRITE);

   always_comb begin
      case (cw.jmp)
         J_ALWAYS: jump_taken = 1'b1;
         J_MODE0:  jump_taken = (mode_ff == MODE_STATIC);
         J_MODE1:  jump_taken = (mode_ff == MODE_FIRST);
         default:  jump_taken = 1'b0;
      endcase
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ph_in        = ph_ff;
      mode_in      = mode_ff;
      ss_in        = ss_ff;
      sfc_in       = sfc_ff;
      cfs_in       = cfs_ff;
      cs_in        = cs_ff;
      dg_in        = dg_ff;
      fsv_in       = fsv_ff;
      tpr_in       = tpr_ff;
      w_in         = w_ff;
      i_in         = i_ff;
      u_in         = u_ff;
      ang_in       = ang_ff;
      dt_in        = dt_ff;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      nw_in        = nw_ff;
      ni_in        = ni_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_in       = neg_ff;
      prod_in      = a_half * b_half;
      prod_sh_in   = {1'b0, part[1]} + {1'b0, part[0]};
      acc_in       = acc_ff;
      res_in       = res_ff;
      pcnt_in      = pcnt_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_count_in = rsp_load ? $signed(pcnt_ff) : rsp_count_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:           mode_in = csr_wr_data[MODE_W-1:0];
            CSR_SPEED_SELF:     ss_in   = $signed(csr_wr_data);
            CSR_SPEED_FROM_CUR: sfc_in  = $signed(csr_wr_data);
            CSR_CUR_FROM_SPEED: cfs_in  = $signed(csr_wr_data);
            CSR_CUR_SELF:       cs_in   = $signed(csr_wr_data);
            CSR_DRIVE_GAIN:     dg_in   = $signed(csr_wr_data);
            CSR_FULL_SCALE:     fsv_in  = csr_wr_data[GAIN_W-1:0];
            CSR_TICKS:          tpr_in  = csr_wr_data[GAIN_W-1:0];
            default:            mode_in = mode_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dt_in    = req_time_step;
               cmd_in   = req_drive_command;
               step_in  = '0;
               ph_in    = PH_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cw.mul) begin
               if (ph_ff == PH_LOAD) begin
                  mag_a_in = mag64(op_a);
                  mag_b_in = mag64(op_b);
                  neg_in   = op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
                  acc_in   = '0;
               end
               if (ph_ff >= PH_ACC_FIRST && ph_ff <= PH_ACC_LAST) begin
                  case (prod_sh_ff)
                     2'd0:    acc_in = acc_ff + {64'd0, prod_ff};
                     2'd1:    acc_in = acc_ff + {32'd0, prod_ff, 32'd0};
                     2'd2:    acc_in = acc_ff + {prod_ff, 64'd0};
                     default: acc_in = acc_ff;
                  endcase
               end
               if (ph_ff == PH_SAT) begin
                  if (neg_ff) begin
                     res_in = ovf ? WIDE_MIN : $signed(64'd0 - mag_sh[WIDE_W-1:0]);
                  end else begin
                     res_in = ovf ? WIDE_MAX : $signed(mag_sh[WIDE_W-1:0]);
                  end
                  // The count keeps only the low bits of the unsaturated product.
                  pcnt_in = neg_ff ? (16'd0 - mag_sh[POS_W-1:0]) : mag_sh[POS_W-1:0];
               end
               if (ph_ff == PH_WRITE) begin
                  case (cw.dst)
                     D_T:     t_in   = res_ff;
                     D_NW:    nw_in  = sat_add64(nw_ff, res_ff);
                     D_NI:    ni_in  = sat_add64(ni_ff, res_ff);
                     D_W:     w_in   = clamp48(res_ff);
                     D_ANG:   ang_in = sat_add64(ang_ff, res_ff);
                     D_U:     u_in   = clamp48(res_ff);
                     default: t_in   = t_ff;
                  endcase
               end
            end
            if (cw.init) begin
               nw_in = WIDE_W'(w_ff);
               ni_in = WIDE_W'(i_ff);
            end
            if (cw.commit_w) begin
               w_in = clamp48(nw_ff);
            end
            if (cw.commit_i) begin
               i_in = clamp48(ni_ff);
            end
            if (step_done) begin
               ph_in = PH_LOAD;
               if (cw.last) begin
                  state_in = ST_DONE;
               end else if (jump_taken) begin
                  step_in = cw.target;
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ph_ff        <= PH_LOAD;
         mode_ff      <= MODE_FIRST;
         ss_ff        <= '0;
         sfc_ff       <= '0;
         cfs_ff       <= '0;
         cs_ff        <= '0;
         dg_ff        <= '0;
         fsv_ff       <= FSV_RESET;
         tpr_ff       <= TPR_RESET;
         w_ff         <= '0;
         i_ff         <= '0;
         u_ff         <= '0;
         ang_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ph_ff        <= ph_in;
         mode_ff      <= mode_in;
         ss_ff        <= ss_in;
         sfc_ff       <= sfc_in;
         cfs_ff       <= cfs_in;
         cs_ff        <= cs_in;
         dg_ff        <= dg_in;
         fsv_ff       <= fsv_in;
         tpr_ff       <= tpr_in;
         w_ff         <= w_in;
         i_ff         <= i_in;
         u_ff         <= u_in;
         ang_ff       <= ang_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      cmd_ff       <= cmd_in;
      t_ff         <= t_in;
      nw_ff        <= nw_in;
      ni_ff        <= ni_in;
      mag_a_ff     <= mag_a_in;
      mag_b_ff     <= mag_b_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      prod_sh_ff   <= prod_sh_in;
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      pcnt_ff      <= pcnt_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC) && (step_ff == 5'd0))
      else $error("accepted beat did not start the microprogram at step zero");

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (step_ff <= STEP_LAST))
      else $error("step counter ran past the end of the microprogram");

   a_phase_only_on_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !cw.mul) |-> (ph_ff == PH_LOAD))
      else $error("multiply phase counter active on a non-multiply step");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished step did not reach the response register");

   a_state_frozen_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(u_ff) && $stable(ang_ff) && $stable(w_ff))
      else $error("motor state changed outside of a step");
`endif

endmodule
